// ----- rtl/brcm_pkg.sv -----
// ----------------------------------------------------------------------------
// brcm_pkg
// Shared types and constants for the broadcast ring cursor manager.
// ----------------------------------------------------------------------------
package brcm_pkg;

    localparam int READER_SLOTS       = 8;
    localparam int SLOT_W             = 3;
    localparam int FRAME_HEADER_BYTES = 24;

    localparam logic [30:0] CAPACITY_RESET = 31'd65536;
    localparam logic [62:0] TIMEOUT_RESET  = 63'd300000000000;

    localparam logic [2:0] CMD_RESERVE    = 3'd0;
    localparam logic [2:0] CMD_COMMIT     = 3'd1;
    localparam logic [2:0] CMD_REGISTER   = 3'd2;
    localparam logic [2:0] CMD_UNREGISTER = 3'd3;
    localparam logic [2:0] CMD_POLL       = 3'd4;
    localparam logic [2:0] CMD_ADVANCE    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_LAPPED    = 3'd4;
    localparam logic [2:0] ST_NO_SLOT   = 3'd5;
    localparam logic [2:0] ST_STALE     = 3'd6;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_SCAN_DONE,
        S_MOD,
        S_FINISH
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture input item
        logic decode;     // compute target/compares
        logic scan_start;
        logic scan_step;
        logic scan_end;   // latch minimum and recheck
        logic mod_start;
        logic mod_step;
        logic finish;     // apply state updates
        logic out_load;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [2:0] command;
        logic       too_large;
        logic       need_scan;
        logic       scan_last;
        logic       need_mod;
        logic       mod_done;
    } t_stat;

endpackage

// ----- rtl/brcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// brcm_ctrl
// Sequencer: steps one request through decode, slot scan, modulo and update.
// ----------------------------------------------------------------------------
module brcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  brcm_pkg::t_stat i_stat,
    output brcm_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    brcm_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brcm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_stall     = 1'b1;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        case (r_state)
            brcm_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = brcm_pkg::S_DECODE;
                end
            end
            brcm_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = brcm_pkg::S_FINISH;
                if (i_stat.command == brcm_pkg::CMD_RESERVE ||
                    i_stat.command == brcm_pkg::CMD_POLL) begin
                    n_state = brcm_pkg::S_CHECK;
                end
            end
            brcm_pkg::S_CHECK: begin
                // decode flags are registered by now
                n_state = brcm_pkg::S_MOD;
                if (i_stat.command == brcm_pkg::CMD_RESERVE) begin
                    if (i_stat.too_large) begin
                        n_state = brcm_pkg::S_FINISH;
                    end else if (i_stat.need_scan) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = brcm_pkg::S_SCAN;
                    end
                end
            end
            brcm_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = brcm_pkg::S_SCAN_DONE;
            end
            brcm_pkg::S_SCAN_DONE: begin
                o_cmd.scan_end = 1'b1;
                n_state        = brcm_pkg::S_MOD;
            end
            brcm_pkg::S_MOD: begin
                // start the modulo only when an offset is needed
                if (i_stat.need_mod) begin
                    o_cmd.mod_start = 1'b1;
                    n_state = brcm_pkg::S_FINISH;
                end else begin
                    n_state = brcm_pkg::S_FINISH;
                end
            end
            brcm_pkg::S_FINISH: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done && !(r_out_valid && i_stall)) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = brcm_pkg::S_IDLE;
                end
            end
            default: n_state = brcm_pkg::S_IDLE;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_busy  = (r_state != brcm_pkg::S_IDLE) || r_out_valid;

endmodule

// ----- rtl/brcm_datapath.sv -----
// ----------------------------------------------------------------------------
// brcm_datapath
// Cursors, reader slot file, min scan and a bit-serial modulo unit.
// ----------------------------------------------------------------------------
module brcm_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brcm_pkg::t_cmd  i_cmd,
    output brcm_pkg::t_stat o_stat,
    input  logic            i_cfg_we,
    input  logic            i_cfg_sel,
    input  logic [62:0]     i_cfg_data,
    input  logic [2:0]      i_command,
    input  logic [30:0]     i_payload_size,
    input  logic [2:0]      i_reader_slot,
    input  logic [31:0]     i_reader_generation,
    input  logic [63:0]     i_reader_position,
    input  logic [30:0]     i_advance_bytes,
    input  logic [62:0]     i_now_ns,
    output logic [2:0]      o_status,
    output logic [29:0]     o_ring_offset,
    output logic [63:0]     o_cursor_out,
    output logic [2:0]      o_slot_out,
    output logic [31:0]     o_generation_out
);

    localparam int NS = brcm_pkg::READER_SLOTS;
    localparam int SW = brcm_pkg::SLOT_W;

    logic [30:0] r_capacity;
    logic [62:0] r_timeout;
    logic [63:0] r_producer, r_published, r_cached_min, r_pending;
    logic [NS-1:0] r_active;
    logic [63:0] r_slot_pos [NS];
    logic [62:0] r_slot_hb  [NS];
    logic [31:0] r_slot_gen [NS];

    // captured request
    logic [2:0]  r_cmd;
    logic [2:0]  r_slot;
    logic [31:0] r_rgen;
    logic [63:0] r_rpos;
    logic [30:0] r_adv;
    logic [62:0] r_now;

    logic [31:0] r_need;
    logic [63:0] r_target;
    logic        r_too_large, r_need_scan, r_full;
    logic [SW-1:0] r_idx;
    logic [63:0] r_min;

    // modulo unit: restoring, one bit per cycle
    logic [63:0] r_mod_dvd;
    logic [30:0] r_mod_rem;
    logic [6:0]  r_mod_cnt;
    logic        r_mod_busy;

    logic [31:0] need_c;
    logic [63:0] target_c;
    logic [63:0] gap_c;
    logic [31:0] rem_shift;
    logic [31:0] rem_sub;
    logic        hb_expired;
    logic [62:0] hb_age;
    logic        free_found;
    logic [SW-1:0] free_idx;
    logic [63:0] npos;

    assign need_c   = 32'(brcm_pkg::FRAME_HEADER_BYTES) +
                      ({1'b0, i_payload_size} + 32'd7 & ~32'd7);
    assign target_c = r_producer + 64'(need_c);
    assign gap_c    = r_target - r_min;
    assign hb_age   = r_now - r_slot_hb[r_idx];
    assign hb_expired = (r_now > r_slot_hb[r_idx]) && (hb_age > r_timeout);
    assign rem_shift = {r_mod_rem, r_mod_dvd[63]};
    assign rem_sub   = rem_shift - {1'b0, r_capacity};
    assign npos      = r_rpos + 64'(r_adv);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = NS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                free_found = 1'b1;
                free_idx   = SW'(k);
            end
        end
    end

    always_comb begin
        o_stat.command   = r_cmd;
        o_stat.too_large = r_too_large;
        o_stat.need_scan = r_need_scan;
        o_stat.scan_last = (r_idx == SW'(NS - 1));
        o_stat.need_mod  = (r_cmd == brcm_pkg::CMD_RESERVE && !r_too_large && !r_full) ||
                           (r_cmd == brcm_pkg::CMD_POLL && r_rpos < r_published &&
                            !(r_producer - r_rpos > 64'(r_capacity)));
        o_stat.mod_done  = !r_mod_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= brcm_pkg::CAPACITY_RESET;
            r_timeout    <= brcm_pkg::TIMEOUT_RESET;
            r_producer   <= '0;
            r_published  <= '0;
            r_cached_min <= '0;
            r_pending    <= '0;
            r_active     <= '0;
            r_mod_busy   <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_slot_pos[k] <= '0;
                r_slot_hb[k]  <= '0;
                r_slot_gen[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_sel == brcm_pkg::CFG_CAPACITY) r_capacity <= i_cfg_data[30:0];
                else r_timeout <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_cmd   <= i_command;
                r_slot  <= i_reader_slot;
                r_rgen  <= i_reader_generation;
                r_rpos  <= i_reader_position;
                r_adv   <= i_advance_bytes;
                r_now   <= i_now_ns;
                r_need  <= need_c;
                r_full  <= 1'b0;
            end
            if (i_cmd.decode) begin
                r_target    <= r_producer + 64'(r_need);
                r_too_large <= r_need > {1'b0, r_capacity};
                r_need_scan <= (r_producer + 64'(r_need) - r_cached_min) > 64'(r_capacity);
                r_min       <= r_producer + 64'(r_need);
            end
            if (i_cmd.scan_start) r_idx <= '0;
            if (i_cmd.scan_step) begin
                if (r_active[r_idx]) begin
                    if (hb_expired) r_active[r_idx] <= 1'b0;
                    else if (r_slot_pos[r_idx] < r_min) r_min <= r_slot_pos[r_idx];
                end
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.scan_end) begin
                r_cached_min <= r_min;
                r_full       <= gap_c > 64'(r_capacity);
            end
            if (i_cmd.mod_start) begin
                r_mod_dvd  <= (r_cmd == brcm_pkg::CMD_POLL) ? r_rpos : r_producer;
                r_mod_rem  <= '0;
                r_mod_cnt  <= 7'd64;
                r_mod_busy <= 1'b1;
            end else if (r_mod_busy && i_cmd.mod_step) begin
                if (!rem_sub[31]) r_mod_rem <= rem_sub[30:0];
                else r_mod_rem <= rem_shift[30:0];
                r_mod_dvd <= {r_mod_dvd[62:0], 1'b0};
                r_mod_cnt <= r_mod_cnt - 7'd1;
                if (r_mod_cnt == 7'd1) r_mod_busy <= 1'b0;
            end
            if (i_cmd.finish) begin
                case (r_cmd)
                    brcm_pkg::CMD_RESERVE: begin
                        if (!r_too_large && !r_full) begin
                            r_pending  <= r_target;
                            r_producer <= r_target;
                        end
                    end
                    brcm_pkg::CMD_COMMIT: r_published <= r_pending;
                    brcm_pkg::CMD_REGISTER: begin
                        if (free_found) begin
                            r_active[free_idx]   <= 1'b1;
                            r_slot_gen[free_idx] <= r_slot_gen[free_idx] + 32'd1;
                            r_slot_pos[free_idx] <= r_rpos;
                            r_slot_hb[free_idx]  <= r_now;
                        end
                    end
                    brcm_pkg::CMD_UNREGISTER: r_active[r_slot] <= 1'b0;
                    brcm_pkg::CMD_ADVANCE: begin
                        if (r_slot_gen[r_slot] == r_rgen) begin
                            r_slot_pos[r_slot] <= npos;
                            r_slot_hb[r_slot]  <= r_now;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status         <= brcm_pkg::ST_OK;
            o_ring_offset    <= '0;
            o_cursor_out     <= '0;
            o_slot_out       <= '0;
            o_generation_out <= '0;
            case (r_cmd)
                brcm_pkg::CMD_RESERVE: begin
                    if (r_too_large) o_status <= brcm_pkg::ST_TOO_LARGE;
                    else if (r_full) o_status <= brcm_pkg::ST_FULL;
                    else begin
                        o_ring_offset <= r_mod_rem[29:0];
                        o_cursor_out  <= r_target;
                    end
                end
                brcm_pkg::CMD_COMMIT: o_cursor_out <= r_pending;
                brcm_pkg::CMD_REGISTER: begin
                    if (free_found) begin
                        o_slot_out       <= free_idx;
                        o_generation_out <= r_slot_gen[free_idx] + 32'd1;
                    end else begin
                        o_status <= brcm_pkg::ST_NO_SLOT;
                    end
                end
                brcm_pkg::CMD_POLL: begin
                    if (r_rpos >= r_published) o_status <= brcm_pkg::ST_NO_DATA;
                    else if (r_producer - r_rpos > 64'(r_capacity))
                        o_status <= brcm_pkg::ST_LAPPED;
                    else begin
                        o_ring_offset <= r_mod_rem[29:0];
                        o_cursor_out  <= r_rpos;
                    end
                end
                brcm_pkg::CMD_ADVANCE: begin
                    o_cursor_out <= npos;
                    if (r_slot_gen[r_slot] != r_rgen) o_status <= brcm_pkg::ST_STALE;
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/broadcast_ring_cursor_manager.sv -----
// ----------------------------------------------------------------------------
// broadcast_ring_cursor_manager
// Producer/reader cursor manager for a byte ring with eight reader slots.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | carries
//  request  | in        | valid / stall    | command and operands
//  result   | out       | valid / stall    | status, offset, cursor, slot, gen
//  config   | in        | valid / ready    | register index and data
//
// A request holds the input through accept, decode and finish; reserve and
// poll add check and modulo start, a reserve that scans the reader slots adds
// the slot scan, and an offset adds the bit-serial modulo by the capacity.
// Reset is synchronous; all cursors and slots clear at once.
// A stalled result holds; one more request may be accepted and wait behind it.
// Config writes are taken only while no request or result is in flight.
module broadcast_ring_cursor_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [30:0] i_payload_size,
    input  logic [2:0]  i_reader_slot,
    input  logic [31:0] i_reader_generation,
    input  logic [63:0] i_reader_position,
    input  logic [30:0] i_advance_bytes,
    input  logic [62:0] i_now_ns,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [29:0] o_ring_offset,
    output logic [63:0] o_cursor_out,
    output logic [2:0]  o_slot_out,
    output logic [31:0] o_generation_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data
);

    brcm_pkg::t_cmd  cmd;
    brcm_pkg::t_stat stat;
    logic busy;

    assign o_cfg_ready = !busy;

    brcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    brcm_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_valid && !busy),
        .i_cfg_sel           (i_cfg_index[0]),
        .i_cfg_data          (i_cfg_data),
        .i_command           (i_command),
        .i_payload_size      (i_payload_size),
        .i_reader_slot       (i_reader_slot),
        .i_reader_generation (i_reader_generation),
        .i_reader_position   (i_reader_position),
        .i_advance_bytes     (i_advance_bytes),
        .i_now_ns            (i_now_ns),
        .o_status            (o_status),
        .o_ring_offset       (o_ring_offset),
        .o_cursor_out        (o_cursor_out),
        .o_slot_out          (o_slot_out),
        .o_generation_out    (o_generation_out)
    );

endmodule
